@@ src/simplex_noise_2d_assert.svh @@
// Assertion macros shared by the simplex noise checker.
`ifndef SIMPLEX_NOISE_2D_ASSERT_SVH
`define SIMPLEX_NOISE_2D_ASSERT_SVH
// Same-cycle implication, clocked on clk, off while rst_n is low.
`define SN2D_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sn2d check failed");
// Next-cycle implication, clocked on clk, off while rst_n is low.
`define SN2D_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sn2d check failed");
`endif

@@ src/sn2d_pkg.sv @@
// Shared types and constants of the 2D simplex noise block.
`timescale 1ns / 1ps
package sn2d_pkg;

    localparam int TBL_ENTRIES = 256;
    localparam int TBL_AW      = $clog2(TBL_ENTRIES);
    localparam int BYTE_W      = 8;

    localparam logic OP_EVALUATE = 1'b0;
    localparam logic OP_WRITE    = 1'b1;

    localparam logic [23:0] SCALE_RESET = 24'd65536;

    // skew F = 0.36603, unskew G = 0.21132, Q.16
    localparam logic [14:0] SKEW_Q16   = 15'd23988;
    localparam logic [13:0] UNSKEW_Q16 = 14'd13849;
    // 1.0, G and 1.0 - 2G, Q.16
    localparam logic signed [21:0] ONE_Q16    = 22'sd65536;
    localparam logic signed [21:0] D2_OFF_Q16 = 22'sd13849;
    localparam logic signed [21:0] D3_OFF_Q16 = 22'sd37838;

    typedef struct packed {
        logic                     is_write;
        logic signed [39:0]       xs;
        logic signed [39:0]       ys;
        logic [TBL_AW-1:0]        tidx;
        logic [BYTE_W-1:0]        tval;
    } fr_item_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

    // gradient . d for the eight fixed directions
    function automatic logic signed [22:0] grad_dot(input logic [2:0] g,
                                                    input logic signed [21:0] dx,
                                                    input logic signed [21:0] dy);
        logic signed [22:0] ex;
        logic signed [22:0] ey;
        logic signed [22:0] r;
        ex = {dx[21], dx};
        ey = {dy[21], dy};
        unique case (g)
            3'd0: r = ex + ey;
            3'd1: r = ey - ex;
            3'd2: r = ex - ey;
            3'd3: r = 23'sd0 - ex - ey;
            3'd4: r = ex;
            3'd5: r = 23'sd0 - ex;
            3'd6: r = ey;
            3'd7: r = 23'sd0 - ey;
            default: r = 23'sd0;
        endcase
        return r;
    endfunction

endpackage

@@ src/simplex_noise_2d.sv @@
// Top level of the 2D simplex noise block.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall): a beat with operation = 0 evaluates
//   noise at (x_coord, y_coord), Q16.16; operation = 1 stores table_value at
//   permutation entry table_index and produces no output beat.
//   Output channel (out_valid / out_stall): one noise_value beat, Q1.15,
//   saturated, per evaluate beat, in input order.
//   Config: APB, scale (Q8.16) at byte address 0; write it only while idle.
// Timing:
//   Throughput is one beat per cycle while the output does not stall; the
//   12-stage evaluation pipe, with its three copies of the permutation
//   table (one for the first lookup level, two for the second), sets that.
//   A stalled output beat holds; the pipe freezes behind it, the two-entry
//   queue fills, and then in_stall rises. Input is still taken meanwhile.
// Reset:
//   rst_n clears all valid state and sets scale to 1.0. The permutation
//   table is not cleared: every entry must be written before it is read.
module simplex_noise_2d (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic signed [31:0]            x_coord,
    input  logic signed [31:0]            y_coord,
    input  logic [sn2d_pkg::TBL_AW-1:0]   table_index,
    input  logic [sn2d_pkg::BYTE_W-1:0]   table_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [15:0]            noise_value
);

    // register index (byte address / 4)
    localparam logic REG_SCALE = 1'b0;

    logic [23:0]         scale_reg;
    logic [23:0]         scale_next;
    logic                cfg_wr;
    logic                fr_push;
    logic                q_pop;
    sn2d_pkg::fr_item_t  fr_item;
    sn2d_pkg::fr_item_t  q_head;
    sn2d_pkg::q_status_t q_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SCALE);

    always_comb
    begin
        scale_next = cfg_wr ? pwdata[23:0] : scale_reg;
        prdata     = (paddr[2] == REG_SCALE) ? {8'b0, scale_reg} : 32'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= sn2d_pkg::SCALE_RESET;
        end
        else
        begin
            scale_reg <= scale_next;
        end
    end

    // front: accept, classify, scale
    sn2d_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .table_index (table_index),
        .table_value (table_value),
        .scale       (scale_reg),
        .q_stat      (q_stat),
        .push        (fr_push),
        .item        (fr_item)
    );

    // decoupling queue
    sn2d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fr_push),
        .push_item (fr_item),
        .pop       (q_pop),
        .head      (q_head),
        .q_stat    (q_stat)
    );

    // back: lookups and noise arithmetic
    sn2d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .q_stat      (q_stat),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .noise_value (noise_value)
    );

endmodule

@@ src/sn2d_ram.sv @@
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module sn2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd0_reg;
    logic [WIDTH-1:0] rd1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rd0_reg <= mem_reg[raddr0];
            rd1_reg <= mem_reg[raddr1];
        end
    end

    assign rdata0 = rd0_reg;
    assign rdata1 = rd1_reg;

endmodule

@@ src/sn2d_front.sv @@
// Front end: accepts beats, classifies them and applies the coordinate scale.
`timescale 1ns / 1ps
module sn2d_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               operation,
    input  logic signed [31:0]                 x_coord,
    input  logic signed [31:0]                 y_coord,
    input  logic [sn2d_pkg::TBL_AW-1:0]        table_index,
    input  logic [sn2d_pkg::BYTE_W-1:0]        table_value,
    input  logic [23:0]                        scale,
    input  sn2d_pkg::q_status_t                q_stat,
    output logic                               push,
    output sn2d_pkg::fr_item_t                 item
);

    logic                 fr_v_reg;
    logic                 fr_v_next;
    sn2d_pkg::fr_item_t   fr_item_reg;
    sn2d_pkg::fr_item_t   fr_item_next;
    logic signed [56:0]   x_prod;
    logic signed [56:0]   y_prod;
    logic                 load;

    assign in_stall = fr_v_reg && q_stat.full;
    assign load     = in_valid && !in_stall;
    assign push     = fr_v_reg && !q_stat.full;
    assign item     = fr_item_reg;

    always_comb
    begin
        x_prod = x_coord * $signed({1'b0, scale});
        y_prod = y_coord * $signed({1'b0, scale});
        fr_item_next.is_write = (operation == sn2d_pkg::OP_WRITE);
        fr_item_next.xs       = x_prod[55:16];
        fr_item_next.ys       = y_prod[55:16];
        fr_item_next.tidx     = table_index;
        fr_item_next.tval     = table_value;
        if (load)
        begin
            fr_v_next = 1'b1;
        end
        else if (push)
        begin
            fr_v_next = 1'b0;
        end
        else
        begin
            fr_v_next = fr_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_v_reg <= 1'b0;
        end
        else
        begin
            fr_v_reg <= fr_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fr_item_reg <= fr_item_next;
        end
    end

endmodule

@@ src/sn2d_queue.sv @@
// Two-entry queue between the front end and the evaluation pipeline.
`timescale 1ns / 1ps
module sn2d_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sn2d_pkg::fr_item_t  push_item,
    input  logic                pop,
    output sn2d_pkg::fr_item_t  head,
    output sn2d_pkg::q_status_t q_stat
);

    sn2d_pkg::fr_item_t slot_reg [2];
    logic               wp_reg;
    logic               wp_next;
    logic               rp_reg;
    logic               rp_next;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;

    assign head             = slot_reg[rp_reg];
    assign q_stat.not_empty = (count_reg != 2'd0);
    assign q_stat.full      = (count_reg == 2'd2);

    always_comb
    begin
        wp_next    = push ? ~wp_reg : wp_reg;
        rp_next    = pop ? ~rp_reg : rp_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= push_item;
        end
    end

endmodule

@@ src/sn2d_back.sv @@
// Evaluation pipeline: skew, hash lookups, corner terms, sum and output register.
`timescale 1ns / 1ps
module sn2d_back (
    input  logic                clk,
    input  logic                rst_n,
    input  sn2d_pkg::fr_item_t  head,
    input  sn2d_pkg::q_status_t q_stat,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  noise_value
);

    localparam int AW = sn2d_pkg::TBL_AW;
    localparam logic signed [47:0] OFF_HI = 48'sd524288;
    localparam logic signed [47:0] OFF_LO = -48'sd524288;

    function automatic logic signed [20:0] clamp_off(input logic signed [47:0] v);
        logic signed [20:0] r;
        if (v > OFF_HI)
        begin
            r = OFF_HI[20:0];
        end
        else if (v < OFF_LO)
        begin
            r = OFF_LO[20:0];
        end
        else
        begin
            r = v[20:0];
        end
        return r;
    endfunction

    logic adv;

    // stage 1: skew factor
    logic               s1_v_reg;
    logic               s1_w_reg;
    logic signed [39:0] s1_xs_reg, s1_ys_reg;
    logic signed [40:0] s1_s_reg, s1_s_next;
    logic [AW-1:0]      s1_tidx_reg;
    logic [7:0]         s1_tval_reg;
    logic signed [40:0] sum_xy;
    logic signed [56:0] skew_prod;

    // stage 2: cell
    logic               s2_v_reg;
    logic               s2_w_reg;
    logic signed [39:0] s2_xs_reg, s2_ys_reg;
    logic signed [25:0] s2_i_reg, s2_i_next, s2_j_reg, s2_j_next;
    logic [AW-1:0]      s2_tidx_reg;
    logic [7:0]         s2_tval_reg;
    logic signed [41:0] sum_xi, sum_yj;

    // stage 3: unskew, first lookups in flight
    logic               s3_v_reg;
    logic               s3_w_reg;
    logic signed [47:0] s3_ax_reg, s3_ax_next, s3_ay_reg, s3_ay_next;
    logic signed [41:0] s3_t_reg, s3_t_next;
    logic [AW-1:0]      s3_i8_reg;
    logic [AW-1:0]      s3_tidx_reg;
    logic [7:0]         s3_tval_reg;
    logic signed [26:0] sum_ij;
    logic [7:0]         l1_rd0, l1_rd1;

    // stage 4: cell offsets
    logic               s4_v_reg;
    logic               s4_w_reg;
    logic signed [20:0] s4_x0_reg, s4_x0_next, s4_y0_reg, s4_y0_next;
    logic [AW-1:0]      s4_i8_reg;
    logic [7:0]         s4_pj0_reg, s4_pj1_reg;
    logic [AW-1:0]      s4_tidx_reg;
    logic [7:0]         s4_tval_reg;

    // stage 5: corner distances, second lookups in flight
    logic               s5_v_reg;
    logic signed [21:0] s5_dx_reg [3];
    logic signed [21:0] s5_dy_reg [3];
    logic signed [21:0] s5_dx_next [3];
    logic signed [21:0] s5_dy_next [3];
    logic               o1;
    logic [AW-1:0]      a0, a1, a2;
    logic [7:0]         l2a_rd0, l2a_rd1, l2b_rd0, l2b_rd1;
    logic [2:0]         gsel [3];

    // stage 6: falloff base and gradient dot
    logic               s6_v_reg;
    logic signed [45:0] s6_c_reg [3];
    logic signed [45:0] s6_c_next [3];
    logic signed [22:0] s6_dot_reg [3];
    logic signed [22:0] s6_dot_next [3];
    logic signed [43:0] sqx [3];
    logic signed [43:0] sqy [3];

    // stage 7: c^2
    logic               s7_v_reg;
    logic [31:0]        s7_c2_reg [3];
    logic [31:0]        s7_c2_next [3];
    logic signed [22:0] s7_dot_reg [3];
    logic [15:0]        c16 [3];

    // stage 8: c^4
    logic               s8_v_reg;
    logic [28:0]        s8_c4_reg [3];
    logic [28:0]        s8_c4_next [3];
    logic signed [22:0] s8_dot_reg [3];
    logic [63:0]        c4_prod [3];

    // stage 9: corner terms
    logic               s9_v_reg;
    logic signed [52:0] s9_term_reg [3];
    logic signed [52:0] s9_term_next [3];

    // stage 10: sum
    logic               s10_v_reg;
    logic signed [54:0] s10_sum_reg, s10_sum_next;

    // stage 11: times 70 plus rounding
    logic               s11_v_reg;
    logic signed [63:0] s11_m_reg, s11_m_next;
    logic signed [63:0] sum_ext;

    // output register
    logic               out_v_reg;
    logic signed [15:0] out_reg, out_next;
    logic signed [30:0] r_full;

    assign adv         = !(out_v_reg && out_stall);
    assign pop         = adv && q_stat.not_empty;
    assign out_valid   = out_v_reg;
    assign noise_value = out_reg;

    // table copies: one for the first lookup level, two for the second,
    // each written at the stage that reads it
    sn2d_ram #(.WIDTH(8), .DEPTH(sn2d_pkg::TBL_ENTRIES)) u_ram_l1 (
        .clk    (clk),
        .we     (adv && s2_v_reg && s2_w_reg),
        .waddr  (s2_tidx_reg),
        .wdata  (s2_tval_reg),
        .re     (adv),
        .raddr0 (s2_j_reg[AW-1:0]),
        .raddr1 (s2_j_reg[AW-1:0] + AW'(1)),
        .rdata0 (l1_rd0),
        .rdata1 (l1_rd1)
    );

    sn2d_ram #(.WIDTH(8), .DEPTH(sn2d_pkg::TBL_ENTRIES)) u_ram_l2a (
        .clk    (clk),
        .we     (adv && s4_v_reg && s4_w_reg),
        .waddr  (s4_tidx_reg),
        .wdata  (s4_tval_reg),
        .re     (adv),
        .raddr0 (a0),
        .raddr1 (a1),
        .rdata0 (l2a_rd0),
        .rdata1 (l2a_rd1)
    );

    sn2d_ram #(.WIDTH(8), .DEPTH(sn2d_pkg::TBL_ENTRIES)) u_ram_l2b (
        .clk    (clk),
        .we     (adv && s4_v_reg && s4_w_reg),
        .waddr  (s4_tidx_reg),
        .wdata  (s4_tval_reg),
        .re     (adv),
        .raddr0 (a2),
        .raddr1 (a2),
        .rdata0 (l2b_rd0),
        .rdata1 (l2b_rd1)
    );

    always_comb
    begin
        // stage 1
        sum_xy    = {head.xs[39], head.xs} + {head.ys[39], head.ys};
        skew_prod = sum_xy * $signed({1'b0, sn2d_pkg::SKEW_Q16});
        s1_s_next = skew_prod[56:16];
        // stage 2
        sum_xi    = {{2{s1_xs_reg[39]}}, s1_xs_reg} + {s1_s_reg[40], s1_s_reg};
        sum_yj    = {{2{s1_ys_reg[39]}}, s1_ys_reg} + {s1_s_reg[40], s1_s_reg};
        s2_i_next = sum_xi[41:16];
        s2_j_next = sum_yj[41:16];
        // stage 3
        sum_ij     = {s2_i_reg[25], s2_i_reg} + {s2_j_reg[25], s2_j_reg};
        s3_t_next  = sum_ij * $signed({1'b0, sn2d_pkg::UNSKEW_Q16});
        s3_ax_next = {{8{s2_xs_reg[39]}}, s2_xs_reg} - {{6{s2_i_reg[25]}}, s2_i_reg, 16'b0};
        s3_ay_next = {{8{s2_ys_reg[39]}}, s2_ys_reg} - {{6{s2_j_reg[25]}}, s2_j_reg, 16'b0};
        // stage 4
        s4_x0_next = clamp_off(s3_ax_reg + {{6{s3_t_reg[41]}}, s3_t_reg});
        s4_y0_next = clamp_off(s3_ay_reg + {{6{s3_t_reg[41]}}, s3_t_reg});
        // stage 5: middle corner and hash addresses
        o1 = (s4_x0_reg > s4_y0_reg);
        a0 = s4_i8_reg + s4_pj0_reg[AW-1:0];
        a1 = s4_i8_reg + AW'(o1) + (o1 ? s4_pj0_reg[AW-1:0] : s4_pj1_reg[AW-1:0]);
        a2 = s4_i8_reg + AW'(1) + s4_pj1_reg[AW-1:0];
        s5_dx_next[0] = 22'sd0 - {s4_x0_reg[20], s4_x0_reg};
        s5_dy_next[0] = 22'sd0 - {s4_y0_reg[20], s4_y0_reg};
        s5_dx_next[1] = s5_dx_next[0] + (o1 ? sn2d_pkg::ONE_Q16 : 22'sd0)
                        - sn2d_pkg::D2_OFF_Q16;
        s5_dy_next[1] = s5_dy_next[0] + (o1 ? 22'sd0 : sn2d_pkg::ONE_Q16)
                        - sn2d_pkg::D2_OFF_Q16;
        s5_dx_next[2] = s5_dx_next[0] + sn2d_pkg::D3_OFF_Q16;
        s5_dy_next[2] = s5_dy_next[0] + sn2d_pkg::D3_OFF_Q16;
        // stage 6
        gsel[0] = l2a_rd0[2:0];
        gsel[1] = l2a_rd1[2:0];
        gsel[2] = l2b_rd0[2:0];
        for (int k = 0; k < 3; k++)
        begin
            sqx[k]         = s5_dx_reg[k] * s5_dx_reg[k];
            sqy[k]         = s5_dy_reg[k] * s5_dy_reg[k];
            s6_c_next[k]   = 46'sd2147483648 - {{2{sqx[k][43]}}, sqx[k]}
                             - {{2{sqy[k][43]}}, sqy[k]};
            s6_dot_next[k] = sn2d_pkg::grad_dot(gsel[k], s5_dx_reg[k], s5_dy_reg[k]);
            // stage 7
            c16[k]         = s6_c_reg[k][45] ? 16'd0 : s6_c_reg[k][31:16];
            s7_c2_next[k]  = c16[k] * c16[k];
            // stage 8
            c4_prod[k]     = s7_c2_reg[k] * s7_c2_reg[k];
            s8_c4_next[k]  = c4_prod[k][60:32];
            // stage 9
            s9_term_next[k] = $signed({1'b0, s8_c4_reg[k]}) * s8_dot_reg[k];
        end
        // stage 10
        s10_sum_next = {{2{s9_term_reg[0][52]}}, s9_term_reg[0]}
                     + {{2{s9_term_reg[1][52]}}, s9_term_reg[1]}
                     + {{2{s9_term_reg[2][52]}}, s9_term_reg[2]};
        // stage 11: sum * 70 + 2^32
        sum_ext    = {{9{s10_sum_reg[54]}}, s10_sum_reg};
        s11_m_next = (sum_ext <<< 6) + (sum_ext <<< 2) + (sum_ext <<< 1)
                     + 64'sd4294967296;
        // output: floor shift and saturate
        r_full = s11_m_reg[63:33];
        if (r_full > 31'sd32767)
        begin
            out_next = 16'sd32767;
        end
        else if (r_full < -31'sd32768)
        begin
            out_next = -16'sd32768;
        end
        else
        begin
            out_next = r_full[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            s6_v_reg  <= 1'b0;
            s7_v_reg  <= 1'b0;
            s8_v_reg  <= 1'b0;
            s9_v_reg  <= 1'b0;
            s10_v_reg <= 1'b0;
            s11_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg  <= q_stat.not_empty;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            // table writes leave the pipe after their last RAM copy
            s5_v_reg  <= s4_v_reg && !s4_w_reg;
            s6_v_reg  <= s5_v_reg;
            s7_v_reg  <= s6_v_reg;
            s8_v_reg  <= s7_v_reg;
            s9_v_reg  <= s8_v_reg;
            s10_v_reg <= s9_v_reg;
            s11_v_reg <= s10_v_reg;
            out_v_reg <= s11_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_w_reg    <= head.is_write;
            s1_xs_reg   <= head.xs;
            s1_ys_reg   <= head.ys;
            s1_s_reg    <= s1_s_next;
            s1_tidx_reg <= head.tidx;
            s1_tval_reg <= head.tval;

            s2_w_reg    <= s1_w_reg;
            s2_xs_reg   <= s1_xs_reg;
            s2_ys_reg   <= s1_ys_reg;
            s2_i_reg    <= s2_i_next;
            s2_j_reg    <= s2_j_next;
            s2_tidx_reg <= s1_tidx_reg;
            s2_tval_reg <= s1_tval_reg;

            s3_w_reg    <= s2_w_reg;
            s3_ax_reg   <= s3_ax_next;
            s3_ay_reg   <= s3_ay_next;
            s3_t_reg    <= s3_t_next;
            s3_i8_reg   <= s2_i_reg[AW-1:0];
            s3_tidx_reg <= s2_tidx_reg;
            s3_tval_reg <= s2_tval_reg;

            s4_w_reg    <= s3_w_reg;
            s4_x0_reg   <= s4_x0_next;
            s4_y0_reg   <= s4_y0_next;
            s4_i8_reg   <= s3_i8_reg;
            s4_pj0_reg  <= l1_rd0;
            s4_pj1_reg  <= l1_rd1;
            s4_tidx_reg <= s3_tidx_reg;
            s4_tval_reg <= s3_tval_reg;

            for (int k = 0; k < 3; k++)
            begin
                s5_dx_reg[k]   <= s5_dx_next[k];
                s5_dy_reg[k]   <= s5_dy_next[k];
                s6_c_reg[k]    <= s6_c_next[k];
                s6_dot_reg[k]  <= s6_dot_next[k];
                s7_c2_reg[k]   <= s7_c2_next[k];
                s7_dot_reg[k]  <= s6_dot_reg[k];
                s8_c4_reg[k]   <= s8_c4_next[k];
                s8_dot_reg[k]  <= s7_dot_reg[k];
                s9_term_reg[k] <= s9_term_next[k];
            end

            s10_sum_reg <= s10_sum_next;
            s11_m_reg   <= s11_m_next;
            out_reg     <= out_next;
        end
    end

    // second read port of the third-corner copy mirrors the first
    logic unused_rd;
    assign unused_rd = ^l2b_rd1;

endmodule

@@ src/sn2d_checker.sv @@
// Port-level checker for the simplex noise block, bound to the top level.
`timescale 1ns / 1ps
`include "simplex_noise_2d_assert.svh"
module sn2d_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic               pready,
    input logic [2:0]         paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] noise_value
);

    `SN2D_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(noise_value))
    `SN2D_ASSERT_NOW(a_out_drop, $fell(out_valid), $past(!out_stall))
    `SN2D_ASSERT_NOW(a_cfg_readback, (psel && penable && pwrite && pready && paddr[2] == 1'b0) ##1 (psel && !pwrite && paddr[2] == 1'b0), prdata[23:0] == $past(pwdata[23:0]))
    `SN2D_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past(out_valid && out_stall))

endmodule

bind simplex_noise_2d sn2d_checker u_sn2d_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .noise_value (noise_value)
);
